// File: sv/qpst_pkg.sv
// qpst_pkg: shared types and constants for the quadrature position and speed tracker
// no dependencies
`default_nettype none
package qpst_pkg;
  localparam int CHANNELS = 4;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SAMPLE = 3'd1;
  localparam logic [2:0] KIND_SETPOS = 3'd2;
  localparam logic [2:0] KIND_CALIB  = 3'd3;
  localparam logic [2:0] KIND_HEALTH = 3'd4;

  localparam logic [1:0] REG_ACTIVE   = 2'd0;
  localparam logic [1:0] REG_CPR      = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam logic [31:0] STALE_MS    = 32'd1000;
  localparam logic [7:0]  FAULT_LIMIT = 8'd50;
  localparam logic [31:0] SAT_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN     = 32'h8000_0000;

  // state codes of the sequencer
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_DIV1 = 7'b0000100,
    ST_FIN1 = 7'b0001000,
    ST_DIV2 = 7'b0010000,
    ST_FIN2 = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

// File: sv/quadrature_position_speed_tracker.sv
// quadrature_position_speed_tracker: top level, per-channel state and sequencer
// uses qpst_pkg; one shared restoring divider (one quotient bit per cycle)
//
// usage: requests enter on in_valid/in_ready with kind, channel, counter_value
// and new_position; every request gives exactly one result on out_valid/out_ready.
// tick, set-position, calibrate, health and unknown requests, and samples that
// do not reach the measurement interval, go from ST_EXEC to ST_OUT, which
// registers their result. a sample that updates the speed runs
// cdiff*1000/elapsed through the shared 42-bit serial divider (a load step,
// the quotient-bit steps and a write-back step), then pps*60/rev_counts the
// same way; the second division is skipped when rev_counts is zero.
// the divider sets the rate.
// in_ready is high only while the block is idle with no result pending, so one
// request is in flight; the next enters in the cycle after the result is accepted.
// when the receiver stalls the result is held in the output register and no new
// request is taken until it is accepted. reset clears the millisecond clock and
// all channel state, and loads active_channels 4, rev_counts 2048 and
// measure_interval_ms 10. configuration is written through cfg_we/cfg_index/
// cfg_data, by the user only while the block is idle; the block does not check.
`default_nettype none
module quadrature_position_speed_tracker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         kind,
  input  wire logic [1:0]         channel,
  input  wire logic [15:0]        counter_value,
  input  wire logic signed [31:0] new_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    valid_res,
  output logic signed [31:0]      position,
  output logic signed [31:0]      pulse_rate,
  output logic signed [31:0]      rev_rate,
  output logic [1:0]              direction,
  output logic                    healthy,
  output logic [7:0]              fault_tally,
  output logic                    calibrated,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  localparam int DW = 42;
  localparam int CW = $clog2(DW + 1);

  qpst_pkg::state_t state;
  logic [2:0]  active_channels;
  logic [15:0] rev_counts;
  logic [15:0] measure_interval_ms;
  logic [31:0] clock_ms;

  logic [15:0] last_raw      [qpst_pkg::CHANNELS];
  logic [31:0] pulse_total   [qpst_pkg::CHANNELS];
  logic [31:0] zero_ref      [qpst_pkg::CHANNELS];
  logic [31:0] snap_ms       [qpst_pkg::CHANNELS];
  logic [31:0] capture_count [qpst_pkg::CHANNELS];
  logic [31:0] pps_value     [qpst_pkg::CHANNELS];
  logic [31:0] rpm_value     [qpst_pkg::CHANNELS];
  logic [1:0]  dir_state     [qpst_pkg::CHANNELS];
  logic [31:0] update_time   [qpst_pkg::CHANNELS];
  logic [7:0]  fault_count   [qpst_pkg::CHANNELS];
  logic        calib_flag    [qpst_pkg::CHANNELS];

  logic [2:0]  req_kind;
  logic [1:0]  req_ch;
  logic [15:0] req_raw;
  logic [31:0] req_pos;

  // serial divider on magnitudes
  logic [DW-1:0] div_q;
  logic [DW-1:0] div_r;
  logic [DW-1:0] div_d;
  logic          div_neg;
  logic [CW-1:0] div_cnt;
  logic [DW:0]   div_trial;
  logic [DW-1:0] div_rsh;

  logic          used;
  logic [15:0]   diff16;
  logic [31:0]   delta;
  logic [31:0]   new_total;
  logic [31:0]   elapsed;
  logic [15:0]   interval;
  logic [31:0]   cdiff;
  logic [DW-1:0] cdiff_ext;
  logic [DW-1:0] prod1;
  logic [DW-1:0] pps_ext;
  logic [DW-1:0] prod2;
  logic [DW-1:0] quot_s;
  logic [31:0]   sat_q;

  assign used = ({1'b0, req_ch} < active_channels);
  assign in_ready = (state == qpst_pkg::ST_IDLE) && !out_valid;

  assign diff16 = req_raw - last_raw[req_ch];
  assign delta = {{16{diff16[15]}}, diff16};
  assign new_total = pulse_total[req_ch] + delta;
  assign elapsed = clock_ms - snap_ms[req_ch];
  assign interval = (measure_interval_ms == 16'd0) ? 16'd1 : measure_interval_ms;
  assign cdiff = pulse_total[req_ch] - capture_count[req_ch];
  assign cdiff_ext = {{(DW-32){cdiff[31]}}, cdiff};
  assign prod1 = cdiff_ext * DW'(1000);
  assign pps_ext = {{(DW-32){pps_value[req_ch][31]}}, pps_value[req_ch]};
  assign prod2 = pps_ext * DW'(60);

  assign div_rsh = {div_r[DW-2:0], div_q[DW-1]};
  assign div_trial = {1'b0, div_rsh} - {1'b0, div_d};
  assign quot_s = div_neg ? (~div_q + DW'(1)) : div_q;

  always_comb begin
    if (!quot_s[DW-1] && quot_s[DW-2:31] != '0) begin
      sat_q = qpst_pkg::SAT_MAX;
    end else if (quot_s[DW-1] && quot_s[DW-2:31] != {(DW-32){1'b1}}) begin
      sat_q = qpst_pkg::SAT_MIN;
    end else begin
      sat_q = quot_s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qpst_pkg::ST_IDLE;
      out_valid <= 1'b0;
      active_channels <= 3'd4;
      rev_counts <= 16'd2048;
      measure_interval_ms <= 16'd10;
      clock_ms <= '0;
      for (int i = 0; i < qpst_pkg::CHANNELS; i++) begin
        last_raw[i] <= '0;
        pulse_total[i] <= '0;
        zero_ref[i] <= '0;
        snap_ms[i] <= '0;
        capture_count[i] <= '0;
        pps_value[i] <= '0;
        rpm_value[i] <= '0;
        dir_state[i] <= qpst_pkg::DIR_STOP;
        update_time[i] <= '0;
        fault_count[i] <= '0;
        calib_flag[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          qpst_pkg::REG_ACTIVE:   active_channels <= cfg_data[2:0];
          qpst_pkg::REG_CPR:      rev_counts <= cfg_data;
          qpst_pkg::REG_INTERVAL: measure_interval_ms <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        qpst_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            req_kind <= kind;
            req_ch <= channel;
            req_raw <= counter_value;
            req_pos <= new_position;
            if (kind == qpst_pkg::KIND_TICK) begin
              clock_ms <= clock_ms + 32'd1;
            end
            state <= qpst_pkg::ST_EXEC;
          end
        end
        qpst_pkg::ST_EXEC: begin
          state <= qpst_pkg::ST_OUT;
          if (used) begin
            case (req_kind)
              qpst_pkg::KIND_SAMPLE: begin
                pulse_total[req_ch] <= new_total;
                last_raw[req_ch] <= req_raw;
                update_time[req_ch] <= clock_ms;
                if (elapsed >= {16'd0, interval}) begin
                  state <= qpst_pkg::ST_DIV1;
                end
              end
              qpst_pkg::KIND_SETPOS: begin
                pulse_total[req_ch] <= req_pos + zero_ref[req_ch];
                capture_count[req_ch] <= req_pos + zero_ref[req_ch];
              end
              qpst_pkg::KIND_CALIB: begin
                zero_ref[req_ch] <= pulse_total[req_ch];
                calib_flag[req_ch] <= 1'b1;
              end
              qpst_pkg::KIND_HEALTH: begin
                if (clock_ms - update_time[req_ch] > qpst_pkg::STALE_MS &&
                    fault_count[req_ch] != 8'hFF) begin
                  fault_count[req_ch] <= fault_count[req_ch] + 8'd1;
                end
              end
              default: ;
            endcase
          end
        end
        qpst_pkg::ST_DIV1: begin
          // pulse_total already updated: load cdiff*1000 / elapsed
          if (cdiff[31]) begin
            dir_state[req_ch] <= (cdiff < 32'hFFFF_FFFB) ? qpst_pkg::DIR_REV
                                                         : qpst_pkg::DIR_STOP;
          end else begin
            dir_state[req_ch] <= (cdiff > 32'd5) ? qpst_pkg::DIR_FWD
                                                 : qpst_pkg::DIR_STOP;
          end
          snap_ms[req_ch] <= clock_ms;
          capture_count[req_ch] <= pulse_total[req_ch];
          div_neg <= prod1[DW-1];
          div_q <= prod1[DW-1] ? (~prod1 + DW'(1)) : prod1;
          div_r <= '0;
          div_d <= {{(DW-32){1'b0}}, elapsed};
          div_cnt <= CW'(DW);
          state <= qpst_pkg::ST_FIN1;
        end
        qpst_pkg::ST_FIN1, qpst_pkg::ST_FIN2: begin
          if (div_cnt != '0) begin
            div_cnt <= div_cnt - CW'(1);
            if (!div_trial[DW]) begin
              div_r <= div_trial[DW-1:0];
              div_q <= {div_q[DW-2:0], 1'b1};
            end else begin
              div_r <= div_rsh;
              div_q <= {div_q[DW-2:0], 1'b0};
            end
          end else if (state == qpst_pkg::ST_FIN1) begin
            pps_value[req_ch] <= sat_q;
            state <= (rev_counts != 16'd0) ? qpst_pkg::ST_DIV2 : qpst_pkg::ST_OUT;
          end else begin
            rpm_value[req_ch] <= sat_q;
            state <= qpst_pkg::ST_OUT;
          end
        end
        qpst_pkg::ST_DIV2: begin
          div_neg <= prod2[DW-1];
          div_q <= prod2[DW-1] ? (~prod2 + DW'(1)) : prod2;
          div_r <= '0;
          div_d <= {{(DW-16){1'b0}}, rev_counts};
          div_cnt <= CW'(DW);
          state <= qpst_pkg::ST_FIN2;
        end
        qpst_pkg::ST_OUT: begin
          out_valid <= 1'b1;
          valid_res <= used;
          position <= used ? pulse_total[req_ch] - zero_ref[req_ch] : '0;
          pulse_rate <= used ? pps_value[req_ch] : '0;
          rev_rate <= used ? rpm_value[req_ch] : '0;
          direction <= used ? dir_state[req_ch] : qpst_pkg::DIR_STOP;
          healthy <= used && (clock_ms - update_time[req_ch] <= qpst_pkg::STALE_MS) &&
                     (fault_count[req_ch] <= qpst_pkg::FAULT_LIMIT);
          fault_tally <= used ? fault_count[req_ch] : '0;
          calibrated <= used && calib_flag[req_ch];
          state <= qpst_pkg::ST_IDLE;
        end
        default: state <= qpst_pkg::ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
